// ===== sv/seq_pkg.sv =====
// ----------------------------------------------------------------------------
// seq_pkg: shared types and codes of the stable sorted event queue
// Request and response item layouts, action and status codes, cell control.
// ----------------------------------------------------------------------------
package seq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 64;
   localparam int DEFAULT_TIME_BITS   = 32;
   localparam int OCC_BITS            = 7;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_POP    = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        action;
      logic [31:0] event_time;
      logic [1:0]  event_kind;
      logic [7:0]  job_number;
      logic [1:0]  stage_number;
      logic [3:0]  station_index;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [31:0]         out_time;
      logic [1:0]          out_kind;
      logic [7:0]          out_job;
      logic [1:0]          out_stage;
      logic [3:0]          out_station;
      logic [OCC_BITS-1:0] occupancy;
   } rsp_type;

   // event fields other than the time key
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] job;
      logic [1:0] stage;
      logic [3:0] station;
   } meta_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage

// ===== sv/seq_stream_if.sv =====
// ----------------------------------------------------------------------------
// seq_stream_if: valid/ready channel
// Carries one payload item per handshake, with source and sink views.
// ----------------------------------------------------------------------------
interface seq_stream_if #(
   parameter type payload_type = seq_pkg::req_type
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/seq_cell.sv =====
// ----------------------------------------------------------------------------
// seq_cell: one slot of the sorted shift-register queue
// Holds one event; shifts right on insert past it, shifts left on pop.
// ----------------------------------------------------------------------------
module seq_cell #(
   parameter int TIME_BITS = seq_pkg::DEFAULT_TIME_BITS,
   parameter int CNT_BITS  = 7,
   parameter int INDEX     = 0
) (
   input  logic                  clock,
   input  seq_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_BITS-1:0]   count,
   input  logic [TIME_BITS-1:0]  new_time,
   input  seq_pkg::meta_type     new_meta,
   input  logic                  left_gt,
   input  logic [TIME_BITS-1:0]  left_time,
   input  seq_pkg::meta_type     left_meta,
   input  logic [TIME_BITS-1:0]  right_time,
   input  seq_pkg::meta_type     right_meta,
   output logic                  gt,
   output logic [TIME_BITS-1:0]  time_ff,
   output seq_pkg::meta_type     meta_ff
);

   logic                 occupied;
   logic [TIME_BITS-1:0] time_in;
   seq_pkg::meta_type    meta_in;

   assign occupied = CNT_BITS'(INDEX) < count;
   // an empty slot counts as later than any event
   assign gt = !occupied || (new_time < time_ff);

   always_comb begin
      time_in = time_ff;
      meta_in = meta_ff;
      if (ctrl.pop) begin
         time_in = right_time;
         meta_in = right_meta;
      end else if (ctrl.insert && gt) begin
         if (left_gt) begin
            time_in = left_time;
            meta_in = left_meta;
         end else begin
            time_in = new_time;
            meta_in = new_meta;
         end
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      meta_ff <= meta_in;
   end

endmodule

// ===== sv/stable_sorted_event_queue.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_event_queue: sorted event queue, ties leave in arrival order
// The result item appears in the cycle after the request is accepted.
// Throughput: one item per cycle unless results stall; every slot compares
// against the new time in parallel and the whole row shifts in the same cycle.
// Reset: synchronous, clears the fill count and the result valid flag; slot
// contents stay undefined until written.
// ----------------------------------------------------------------------------
module stable_sorted_event_queue #(
   parameter int QUEUE_DEPTH = seq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TIME_BITS   = seq_pkg::DEFAULT_TIME_BITS
) (
   input logic         clock,
   input logic         reset,
   seq_stream_if.sink   req_ch,
   seq_stream_if.source rsp_ch
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   seq_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                 accept, full, empty;
   seq_pkg::cell_ctrl_type ctrl;
   logic [TIME_BITS-1:0] new_time;
   seq_pkg::meta_type    new_meta;

   logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
   seq_pkg::meta_type    cell_meta [QUEUE_DEPTH];
   logic                 cell_gt   [QUEUE_DEPTH];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign empty        = count_ff == '0;

   assign ctrl.insert = accept && (req_ch.data.action == seq_pkg::ACTION_INSERT) && !full;
   assign ctrl.pop    = accept && (req_ch.data.action == seq_pkg::ACTION_POP) && !empty;

   assign new_time      = TIME_BITS'(req_ch.data.event_time);
   assign new_meta.kind    = req_ch.data.event_kind;
   assign new_meta.job     = req_ch.data.job_number;
   assign new_meta.stage   = req_ch.data.stage_number;
   assign new_meta.station = req_ch.data.station_index;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 left_gt;
      logic [TIME_BITS-1:0] left_time, right_time;
      seq_pkg::meta_type    left_meta, right_meta;

      if (i == 0) begin : g_head
         assign left_gt   = 1'b0;
         assign left_time = new_time;
         assign left_meta = new_meta;
      end else begin : g_body
         assign left_gt   = cell_gt[i-1];
         assign left_time = cell_time[i-1];
         assign left_meta = cell_meta[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_time = cell_time[i];
         assign right_meta = cell_meta[i];
      end else begin : g_inner
         assign right_time = cell_time[i+1];
         assign right_meta = cell_meta[i+1];
      end

      seq_cell #(
         .TIME_BITS(TIME_BITS),
         .CNT_BITS (CNT_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .new_time  (new_time),
         .new_meta  (new_meta),
         .left_gt   (left_gt),
         .left_time (left_time),
         .left_meta (left_meta),
         .right_time(right_time),
         .right_meta(right_meta),
         .gt        (cell_gt[i]),
         .time_ff   (cell_time[i]),
         .meta_ff   (cell_meta[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         priority if (req_ch.data.action == seq_pkg::ACTION_INSERT && full) begin
            rsp_data_in.status = seq_pkg::STATUS_FULL;
         end else if (req_ch.data.action == seq_pkg::ACTION_POP && empty) begin
            rsp_data_in.status = seq_pkg::STATUS_EMPTY;
         end else begin
            rsp_data_in.status = seq_pkg::STATUS_DONE;
         end
         if (ctrl.pop) begin
            rsp_data_in.out_time    = 32'(cell_time[0]);
            rsp_data_in.out_kind    = cell_meta[0].kind;
            rsp_data_in.out_job     = cell_meta[0].job;
            rsp_data_in.out_stage   = cell_meta[0].stage;
            rsp_data_in.out_station = cell_meta[0].station;
         end
         rsp_data_in.occupancy = seq_pkg::OCC_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// ===== sv/seq_checker.sv =====
// ----------------------------------------------------------------------------
// seq_checker: port-level checks of the stable sorted event queue
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module seq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input seq_pkg::rsp_type rsp_data
);

   // hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == seq_pkg::STATUS_EMPTY |->
      rsp_data.occupancy == '0 && rsp_data.out_time == '0)
      else $error("pop on empty reported data or occupancy");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == seq_pkg::STATUS_FULL |->
      rsp_data.occupancy != '0 && rsp_data.out_time == '0)
      else $error("dropped insert reported bad fields");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stable_sorted_event_queue seq_checker u_seq_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_data (rsp_ch.data)
);
